// ===== hdl/deep_contact_shadow_assert.svh =====
// Assertion macros shared by the contact shadow checker
`ifndef DEEP_CONTACT_SHADOW_ASSERT_SVH
`define DEEP_CONTACT_SHADOW_ASSERT_SVH

// Check a property on the rising clock, ignored while reset is asserted
`define DCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on the rising clock, during reset too
`define DCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/dcs_pkg.sv =====
// Types, constants and codes of the contact shadow block
`default_nettype none
package dcs_pkg;
  localparam int unsigned MaxWidth   = 128;
  localparam int unsigned MaxHeight  = 128;
  localparam int unsigned MaxSamples = 4;
  localparam int unsigned MaxRadius  = 10;
  localparam int unsigned Pixels     = MaxWidth * MaxHeight;
  localparam int unsigned PixAw      = $clog2(Pixels);
  localparam int unsigned CoordW     = $clog2(MaxWidth);
  localparam int unsigned LaneW      = $clog2(MaxSamples);
  localparam int unsigned CntW       = LaneW + 1;
  localparam int unsigned NumW       = 30;
  localparam int unsigned DenW       = 9;
  localparam int unsigned AccW       = 11;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_ANSWER  = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_WIDTH     = 3'd0,
    CFG_HEIGHT    = 3'd1,
    CFG_PROXIMITY = 3'd2,
    CFG_BIAS      = 3'd3,
    CFG_INTENSITY = 3'd4,
    CFG_RADIUS    = 3'd5,
    CFG_SPARE6    = 3'd6,
    CFG_SPARE7    = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_LOAD,
    S_QSETUP,
    S_QSCAN,
    S_QDRAIN,
    S_MUL,
    S_DIVSTART,
    S_DIVWAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/dcs_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none
module dcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write one word, read one word with the read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/dcs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle
`default_nettype none
module dcs_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dcs_pkg::div_req_t req_i,
  output dcs_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned StepW = $clog2(dcs_pkg::NumW + 1);

  logic [dcs_pkg::NumW-1:0] num_q, num_d;
  logic [dcs_pkg::NumW-1:0] quo_q, quo_d;
  logic [dcs_pkg::DenW-1:0] den_q, den_d;
  logic [dcs_pkg::DenW:0]   rem_q, rem_d;
  logic [StepW-1:0]         step_q, step_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [dcs_pkg::DenW:0]   trial;

  // load a new division on start, else shift in the next dividend bit and try a subtract
  always_comb begin
    trial  = {rem_q[dcs_pkg::DenW-1:0], num_q[dcs_pkg::NumW-1]};
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      step_d = StepW'(dcs_pkg::NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[dcs_pkg::NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[dcs_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[dcs_pkg::NumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

// ===== hdl/dcs_match.sv =====
// Contact test of one pixel's stored depths against the query depth
`default_nettype none
module dcs_match (
  input  wire logic [dcs_pkg::MaxSamples-1:0][31:0] depth_i,
  input  wire logic [dcs_pkg::CntW-1:0]             fill_i,
  input  wire logic [31:0]                          query_i,
  input  wire logic [30:0]                          bias_i,
  input  wire logic [30:0]                          prox_i,
  output logic      [dcs_pkg::CntW-1:0]             hits_o
);
  logic [32:0] diff [dcs_pkg::MaxSamples];
  logic [32:0] absd [dcs_pkg::MaxSamples];
  logic [dcs_pkg::MaxSamples-1:0] hit;

  // count lanes that hold a sample and sit within the contact band
  always_comb begin
    hits_o = '0;
    for (int s = 0; s < dcs_pkg::MaxSamples; s++) begin
      diff[s] = {depth_i[s][31], depth_i[s]} - {query_i[31], query_i};
      absd[s] = diff[s][32] ? (33'd0 - diff[s]) : diff[s];
      hit[s]  = ({1'b0, fill_i} > (dcs_pkg::CntW + 1)'(s)) &&
                (absd[s] >= {2'b0, bias_i}) && (absd[s] < {2'b0, prox_i});
      hits_o  = hits_o + dcs_pkg::CntW'(hit[s]);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/deep_contact_shadow.sv =====
// Top level of the deep-sample contact shadow estimator
//
//  port group   dir   tdata (low bit up)                        tuser
//  s_axis       in    pixel_x 7, pixel_y 7, sample_depth 32     opcode 2
//  m_axis       out   shadow_value 16, contact_count 11         status 2
//  cfg          in    index 3 bit, data 31 bit, write enable    -
//
// Clear: one pixel count per cycle over the count memory, then output.
// Load: count read, write back, output. Query: one memory row per cycle over the
// clipped neighbor pixels (0 to 441), then 30 quotient bits and a done pulse in the
// divider, then output. A stalled receiver holds the output step.
// After reset the same sweep over the count memory runs; no beat is taken meanwhile.
// A finished result waits in the output register while the next beat enters.
`default_nettype none
module deep_contact_shadow (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // pixel_x, pixel_y, sample_depth
  input  wire logic [1:0]  s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // shadow_value, contact_count
  output logic [1:0]       m_axis_tuser,  // status
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [30:0] cfg_data_i
);
  localparam int unsigned CW = dcs_pkg::CoordW;
  localparam int unsigned AW = dcs_pkg::PixAw;
  localparam int unsigned NS = dcs_pkg::MaxSamples;

  dcs_pkg::state_e state_q, state_d;

  // configuration
  logic [7:0]  width_q, height_q;
  logic [30:0] prox_q, bias_q;
  logic [14:0] inten_q;
  logic [3:0]  radius_q;

  // item
  logic [CW-1:0] px_q, py_q;
  logic [31:0]   depth_q;
  logic          emit_q;

  // scan
  logic [AW-1:0] sweep_q;
  logic [CW-1:0] x0_q, x1_q, y1_q, cx_q, cy_q;
  logic          empty_q, rd_vld_q;
  logic [dcs_pkg::AccW-1:0] acc_q;
  logic [dcs_pkg::DenW-1:0] area_q;
  logic [25:0]   prod_q;

  // result
  dcs_pkg::status_e pend_st_q;
  logic [15:0]   pend_sh_q;
  logic [10:0]   pend_ct_q;
  logic [1:0]    m_user_q;
  logic [31:0]   m_data_q;
  logic          m_vld_q;

  logic [7:0] w_eff, h_eff;
  logic [3:0] r_eff;
  logic       accept, out_free, last_pix;

  // memories
  logic [AW-1:0]  raddr, cnt_waddr;
  logic           cnt_we;
  logic [dcs_pkg::CntW-1:0] cnt_wdata, cnt_rdata, hits;
  logic [NS-1:0]  dep_we;
  logic [NS-1:0][31:0] dep_rdata;

  dcs_pkg::div_req_t div_req;
  dcs_pkg::div_rsp_t div_rsp;

  assign w_eff    = (width_q > 8'(dcs_pkg::MaxWidth)) ? 8'(dcs_pkg::MaxWidth) : width_q;
  assign h_eff    = (height_q > 8'(dcs_pkg::MaxHeight)) ? 8'(dcs_pkg::MaxHeight) : height_q;
  assign r_eff    = (radius_q == 4'd0) ? 4'd1 :
                    (radius_q > 4'(dcs_pkg::MaxRadius)) ? 4'(dcs_pkg::MaxRadius) : radius_q;
  assign s_axis_tready = (state_q == dcs_pkg::S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_vld_q || m_axis_tready;
  assign last_pix = (cx_q == x1_q) && (cy_q == y1_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dcs_pkg::S_SWEEP: begin
        if (sweep_q == AW'(dcs_pkg::Pixels - 1)) begin
          state_d = emit_q ? dcs_pkg::S_OUT : dcs_pkg::S_IDLE;
        end
      end
      dcs_pkg::S_IDLE: begin
        if (accept) begin
          unique case (dcs_pkg::opcode_e'(s_axis_tuser))
            dcs_pkg::OP_CLEAR: state_d = dcs_pkg::S_SWEEP;
            dcs_pkg::OP_LOAD:  state_d = dcs_pkg::S_LOAD;
            dcs_pkg::OP_QUERY: state_d = dcs_pkg::S_QSETUP;
            default:           state_d = dcs_pkg::S_OUT;
          endcase
        end
      end
      dcs_pkg::S_LOAD:     state_d = dcs_pkg::S_OUT;
      dcs_pkg::S_QSETUP:   state_d = dcs_pkg::S_QSCAN;
      dcs_pkg::S_QSCAN: begin
        if (empty_q || last_pix) begin
          state_d = dcs_pkg::S_QDRAIN;
        end
      end
      dcs_pkg::S_QDRAIN:   state_d = dcs_pkg::S_MUL;
      dcs_pkg::S_MUL:      state_d = dcs_pkg::S_DIVSTART;
      dcs_pkg::S_DIVSTART: state_d = dcs_pkg::S_DIVWAIT;
      dcs_pkg::S_DIVWAIT: begin
        if (div_rsp.done) begin
          state_d = dcs_pkg::S_OUT;
        end
      end
      dcs_pkg::S_OUT: begin
        if (out_free) begin
          state_d = dcs_pkg::S_IDLE;
        end
      end
      default: state_d = dcs_pkg::S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    raddr     = {cy_q, cx_q};
    cnt_we    = 1'b0;
    cnt_waddr = {py_q, px_q};
    cnt_wdata = cnt_rdata + 1'b1;
    dep_we    = '0;
    div_req   = '0;
    unique case (state_q)
      dcs_pkg::S_SWEEP: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_q;
        cnt_wdata = '0;
      end
      dcs_pkg::S_IDLE: begin
        raddr = {s_axis_tdata[2*CW-1:CW], s_axis_tdata[CW-1:0]};
      end
      dcs_pkg::S_LOAD: begin
        if (!empty_q && cnt_rdata < dcs_pkg::CntW'(NS)) begin
          cnt_we = 1'b1;
          dep_we[cnt_rdata[dcs_pkg::LaneW-1:0]] = 1'b1;
        end
      end
      dcs_pkg::S_DIVSTART: begin
        div_req.start = 1'b1;
        div_req.num   = {1'b0, prod_q, 3'b000} + dcs_pkg::NumW'(area_q) - 1'b1;
        div_req.den   = area_q;
      end
      default: ;
    endcase
  end

  dcs_ram #(.Width(dcs_pkg::CntW), .Depth(dcs_pkg::Pixels)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  for (genvar g = 0; g < NS; g++) begin : g_lane
    dcs_ram #(.Width(32), .Depth(dcs_pkg::Pixels)) u_dep_ram (
      .clk_i   (clk_i),
      .we_i    (dep_we[g]),
      .waddr_i ({py_q, px_q}),
      .wdata_i (depth_q),
      .raddr_i (raddr),
      .rdata_o (dep_rdata[g])
    );
  end

  dcs_match u_match (
    .depth_i (dep_rdata),
    .fill_i  (cnt_rdata),
    .query_i (depth_q),
    .bias_i  (bias_q),
    .prox_i  (prox_q),
    .hits_o  (hits)
  );

  dcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dcs_pkg::S_SWEEP;
      sweep_q  <= '0;
      emit_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
      m_user_q <= dcs_pkg::ST_OK;
      width_q  <= 8'd128;
      height_q <= 8'd128;
      prox_q   <= 31'd32768;
      bias_q   <= 31'd655;
      inten_q  <= 15'd2048;
      radius_q <= 4'd3;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == dcs_pkg::S_QSCAN) && !empty_q;
      if (state_q == dcs_pkg::S_SWEEP) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (accept) begin
        emit_q <= 1'b1;
      end
      // load a new result beat, or drop the one just taken
      if (state_q == dcs_pkg::S_OUT && out_free) begin
        m_vld_q  <= 1'b1;
        m_user_q <= pend_st_q;
      end else if (m_vld_q && m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (dcs_pkg::cfg_idx_e'(cfg_addr_i))
          dcs_pkg::CFG_WIDTH:     width_q  <= cfg_data_i[7:0];
          dcs_pkg::CFG_HEIGHT:    height_q <= cfg_data_i[7:0];
          dcs_pkg::CFG_PROXIMITY: prox_q   <= cfg_data_i;
          dcs_pkg::CFG_BIAS:      bias_q   <= cfg_data_i;
          dcs_pkg::CFG_INTENSITY: inten_q  <= cfg_data_i[14:0];
          dcs_pkg::CFG_RADIUS:    radius_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // bounds of the clipped neighborhood
  logic signed [9:0] lo_x, hi_x, lo_y, hi_y, wm1, hm1;
  logic [4:0] side;
  always_comb begin
    lo_x = $signed({3'b0, px_q}) - $signed({6'b0, r_eff});
    hi_x = $signed({3'b0, px_q}) + $signed({6'b0, r_eff});
    lo_y = $signed({3'b0, py_q}) - $signed({6'b0, r_eff});
    hi_y = $signed({3'b0, py_q}) + $signed({6'b0, r_eff});
    wm1  = $signed({2'b0, w_eff}) - 10'sd1;
    hm1  = $signed({2'b0, h_eff}) - 10'sd1;
    if (lo_x < 0) lo_x = '0;
    if (lo_y < 0) lo_y = '0;
    if (hi_x > wm1) hi_x = wm1;
    if (hi_y > hm1) hi_y = hm1;
    side = {r_eff, 1'b1};
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dcs_pkg::S_IDLE: begin
        px_q    <= s_axis_tdata[CW-1:0];
        py_q    <= s_axis_tdata[2*CW-1:CW];
        depth_q <= s_axis_tdata[45:14];
        empty_q <= ({1'b0, s_axis_tdata[CW-1:0]} >= w_eff) ||
                   ({1'b0, s_axis_tdata[2*CW-1:CW]} >= h_eff);
        acc_q     <= '0;
        pend_st_q <= dcs_pkg::ST_OK;
        pend_sh_q <= '0;
        pend_ct_q <= '0;
      end
      dcs_pkg::S_LOAD: begin
        if (empty_q || cnt_rdata >= dcs_pkg::CntW'(NS)) begin
          pend_st_q <= dcs_pkg::ST_DROPPED;
        end
      end
      dcs_pkg::S_QSETUP: begin
        empty_q <= (lo_x > hi_x) || (lo_y > hi_y);
        x0_q    <= CW'(lo_x);
        x1_q    <= CW'(hi_x);
        y1_q    <= CW'(hi_y);
        cx_q    <= CW'(lo_x);
        cy_q    <= CW'(lo_y);
        area_q  <= {4'b0, side} * {4'b0, side};
      end
      dcs_pkg::S_QSCAN: begin
        if (cx_q == x1_q) begin
          cx_q <= x0_q;
          cy_q <= cy_q + 1'b1;
        end else begin
          cx_q <= cx_q + 1'b1;
        end
      end
      dcs_pkg::S_MUL: begin
        prod_q <= inten_q * acc_q;
      end
      dcs_pkg::S_DIVWAIT: begin
        pend_st_q <= dcs_pkg::ST_ANSWER;
        pend_ct_q <= acc_q;
        pend_sh_q <= (div_rsp.quo >= dcs_pkg::NumW'(32768)) ? 16'd0 :
                     16'(dcs_pkg::NumW'(32768) - div_rsp.quo);
      end
      default: ;
    endcase
    if (rd_vld_q) begin
      acc_q <= acc_q + dcs_pkg::AccW'(hits);
    end
    if (state_q == dcs_pkg::S_OUT && out_free) begin
      m_data_q <= {5'b0, pend_ct_q, pend_sh_q};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
endmodule
`default_nettype wire

// ===== hdl/dcs_chk.sv =====
// Port-level checker of the contact shadow block and its bind
`default_nettype none
`include "deep_contact_shadow_assert.svh"
module dcs_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  `DCS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
              "result beat lost")
  `DCS_ASSERT(a_busy_after_beat, s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
              "beat taken while busy")
  `DCS_ASSERT(a_zero_unless_query,
              m_axis_tvalid && (m_axis_tuser != dcs_pkg::ST_ANSWER) |-> m_axis_tdata == 32'd0,
              "nonzero payload")
  `DCS_ASSERT(a_query_range,
              m_axis_tvalid && (m_axis_tuser == dcs_pkg::ST_ANSWER) |->
              (m_axis_tdata[15:0] <= 16'd32768) && (m_axis_tdata[26:16] <= 11'd1764),
              "answer out of range")
  `DCS_ASSERT(a_status_code, m_axis_tuser != dcs_pkg::ST_UNUSED, "unused status code")
endmodule

bind deep_contact_shadow dcs_chk u_dcs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== tb/sv/deep_contact_shadow_test.sv =====
// Self-checking testbench for the deep-sample contact shadow estimator
`timescale 1ns / 1ps
`default_nettype none
module deep_contact_shadow_test;
  localparam int unsigned StallLimit = 60000;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned TailCycles = 600;

  // Shadow predictor and store of pending answers
  class shadow_scoreboard;
    typedef struct {
      dcs_pkg::status_e st;
      bit [15:0]        shade;
      bit [10:0]        hits;
    } answer_t;

    answer_t   answers_q[$];
    bit [31:0] depth_mem[dcs_pkg::Pixels * dcs_pkg::MaxSamples];
    bit [2:0]  fill[dcs_pkg::Pixels];
    bit [7:0]  width_r, height_r;
    bit [30:0] prox_r, bias_r;
    bit [14:0] inten_r;
    bit [3:0]  radius_r;
    int        errors, results, contacts;

    function new();
      width_r  = 8'd128;
      height_r = 8'd128;
      prox_r   = 31'd32768;
      bias_r   = 31'd655;
      inten_r  = 15'd2048;
      radius_r = 4'd3;
    endfunction

    function void set_reg(dcs_pkg::cfg_idx_e idx, bit [30:0] v);
      case (idx)
        dcs_pkg::CFG_WIDTH:     width_r  = v[7:0];
        dcs_pkg::CFG_HEIGHT:    height_r = v[7:0];
        dcs_pkg::CFG_PROXIMITY: prox_r   = v;
        dcs_pkg::CFG_BIAS:      bias_r   = v;
        dcs_pkg::CFG_INTENSITY: inten_r  = v[14:0];
        dcs_pkg::CFG_RADIUS:    radius_r = v[3:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted beat to the store and queue its answer
    function void note_item(dcs_pkg::opcode_e op, bit [6:0] x, bit [6:0] y, bit [31:0] d);
      answer_t a;
      int w, h, r, ny, nx, pix;
      longint dq, zn, ad, cnt, area, num, dark;
      w = (width_r > dcs_pkg::MaxWidth) ? dcs_pkg::MaxWidth : width_r;
      h = (height_r > dcs_pkg::MaxHeight) ? dcs_pkg::MaxHeight : height_r;
      r = (radius_r < 1) ? 1 : ((radius_r > dcs_pkg::MaxRadius) ? dcs_pkg::MaxRadius : radius_r);
      a.st = dcs_pkg::ST_OK;
      a.shade = 16'd0;
      a.hits = 11'd0;
      case (op)
        dcs_pkg::OP_CLEAR: foreach (fill[i]) fill[i] = 3'd0;
        dcs_pkg::OP_LOAD: begin
          pix = y * dcs_pkg::MaxWidth + x;
          if (x >= w || y >= h || fill[pix] >= dcs_pkg::MaxSamples) begin
            a.st = dcs_pkg::ST_DROPPED;
          end else begin
            depth_mem[pix * dcs_pkg::MaxSamples + fill[pix]] = d;
            fill[pix] = fill[pix] + 3'd1;
          end
        end
        dcs_pkg::OP_QUERY: begin
          dq = longint'($signed(d));
          cnt = 0;
          for (int dy = -r; dy <= r; dy++) begin
            ny = y + dy;
            if (ny < 0 || ny >= h) continue;
            for (int dx = -r; dx <= r; dx++) begin
              nx = x + dx;
              if (nx < 0 || nx >= w) continue;
              pix = ny * dcs_pkg::MaxWidth + nx;
              for (int s = 0; s < fill[pix]; s++) begin
                zn = longint'($signed(depth_mem[pix * dcs_pkg::MaxSamples + s]));
                ad = zn - dq;
                if (ad < 0) ad = -ad;
                if (ad >= longint'(bias_r) && ad < longint'(prox_r)) cnt++;
              end
            end
          end
          if (cnt > 2047) cnt = 2047;
          area = (2 * r + 1) * (2 * r + 1);
          num = longint'(inten_r) * cnt * 8;
          dark = (num + area - 1) / area;
          a.st = dcs_pkg::ST_ANSWER;
          a.shade = (dark >= 32768) ? 16'd0 : 16'(32768 - dark);
          a.hits = 11'(cnt);
          if (cnt != 0) contacts++;
        end
        default: ;
      endcase
      answers_q.insert(answers_q.size(), a);
    endfunction

    task report(string what);
      errors++;
      $display("tb: mismatch: %s", what);
    endtask

    // Compare one result beat with the oldest pending answer
    task check_beat(dcs_pkg::status_e st, bit [15:0] sh, bit [10:0] c);
      answer_t a;
      results++;
      if (answers_q.size() == 0) begin
        report("result beat with no answer pending");
      end else begin
        a = answers_q.pop_front();
        if (st != a.st)
          report($sformatf("status %0d, want %0d", st, a.st));
        if (sh != a.shade)
          report($sformatf("shadow_value %0d, want %0d", sh, a.shade));
        if (c != a.hits)
          report($sformatf("contact_count %0d, want %0d", c, a.hits));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // pixel_x, pixel_y, sample_depth
  logic [1:0]  s_axis_tuser = '0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // shadow_value, contact_count
  logic [1:0]  m_axis_tuser;       // status
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [30:0] cfg_data_i = '0;

  shadow_scoreboard sb = new();
  int send_idle_pct, recv_stall_pct;
  bit hold_req;
  int items_sent, idle_count;
  int cx, cy;
  bit [31:0] base_depth;
  int spread;

  deep_contact_shadow DUT (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watch both handshakes and the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(dcs_pkg::opcode_e'(s_axis_tuser), s_axis_tdata[6:0],
                     s_axis_tdata[13:7], s_axis_tdata[45:14]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_beat(dcs_pkg::status_e'(m_axis_tuser), m_axis_tdata[15:0],
                      m_axis_tdata[26:16]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= StallLimit) begin
        $display("tb: watchdog expired with %0d answers pending", sb.answers_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one beat, with an optional gap first, and hold until taken
  task automatic send_item(dcs_pkg::opcode_e op, bit [6:0] x, bit [6:0] y, bit [31:0] d);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, d, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop offering and wait for every pending answer
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.answers_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(dcs_pkg::cfg_idx_e idx, bit [30:0] v);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  // Build one beat: mostly clustered loads and queries, some noise
  task automatic random_item();
    int k;
    bit [6:0] x, y;
    bit [31:0] d;
    k = $urandom_range(0, 99);
    x = 7'(cx + $urandom_range(0, 6) - 3);
    y = 7'(cy + $urandom_range(0, 6) - 3);
    d = base_depth + 32'($urandom_range(0, spread) - spread / 2);
    if (k < 5)
      send_item(dcs_pkg::OP_NONE, 7'($urandom), 7'($urandom), $urandom);
    else if (k < 15)
      send_item(k < 10 ? dcs_pkg::OP_LOAD : dcs_pkg::OP_QUERY, 7'($urandom), 7'($urandom),
                $urandom);
    else if (k < 55)
      send_item(dcs_pkg::OP_LOAD, x, y, d);
    else
      send_item(dcs_pkg::OP_QUERY, x, y, d);
  endtask

  task automatic run_phase(bit [7:0] w, bit [7:0] h, bit [30:0] prox, bit [30:0] bias,
                           bit [14:0] inten, bit [3:0] rad, int sidle, int rstall,
                           int spr, int n, bit hold);
    int lim;
    drain();
    write_reg(dcs_pkg::CFG_WIDTH, 31'(w));
    write_reg(dcs_pkg::CFG_HEIGHT, 31'(h));
    write_reg(dcs_pkg::CFG_PROXIMITY, prox);
    write_reg(dcs_pkg::CFG_BIAS, bias);
    write_reg(dcs_pkg::CFG_INTENSITY, 31'(inten));
    write_reg(dcs_pkg::CFG_RADIUS, 31'(rad));
    cfg_we_i <= 1'b0;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    spread = spr;
    base_depth = $urandom;
    lim = (w == 0) ? 128 : ((w > 128) ? 128 : w);
    cx = $urandom_range(0, lim - 1);
    lim = (h == 0) ? 128 : ((h > 128) ? 128 : h);
    cy = $urandom_range(0, lim - 1);
    send_item(dcs_pkg::OP_CLEAR, 7'($urandom), 7'($urandom), $urandom);
    // start the hold-off once the clear sweep is over
    random_item();
    if (hold) hold_req = 1'b1;
    repeat (n - 1) random_item();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under the reset settings
    send_item(dcs_pkg::OP_QUERY, 7'd0, 7'd0, 32'h0);
    repeat (4) send_item(dcs_pkg::OP_LOAD, 7'd5, 7'd5, 32'h0001_0000);
    send_item(dcs_pkg::OP_LOAD, 7'd5, 7'd5, 32'h0001_0000);
    send_item(dcs_pkg::OP_LOAD, 7'd127, 7'd127, 32'h8000_0000);
    send_item(dcs_pkg::OP_LOAD, 7'd0, 7'd0, 32'h7FFF_FFFF);
    send_item(dcs_pkg::OP_LOAD, 7'd126, 7'd127, 32'h8000_4000);
    send_item(dcs_pkg::OP_QUERY, 7'd5, 7'd5, 32'h0001_03E8);
    send_item(dcs_pkg::OP_QUERY, 7'd6, 7'd6, 32'h0001_0000);
    send_item(dcs_pkg::OP_QUERY, 7'd8, 7'd8, 32'h0000_8000);
    send_item(dcs_pkg::OP_QUERY, 7'd127, 7'd127, 32'h8000_1000);
    send_item(dcs_pkg::OP_QUERY, 7'd0, 7'd0, 32'h7FFF_F000);
    send_item(dcs_pkg::OP_QUERY, 7'd0, 7'd0, 32'h8000_0000);
    send_item(dcs_pkg::OP_NONE, 7'd127, 7'd127, 32'hFFFF_FFFF);
    send_item(dcs_pkg::OP_CLEAR, 7'd0, 7'd0, 32'h0);
    send_item(dcs_pkg::OP_QUERY, 7'd5, 7'd5, 32'h0001_03E8);

    // Random phases over several register settings and idle patterns
    run_phase(128, 128, 32768, 655, 2048, 3, 0, 0, 65536, 80, 0);
    run_phase(1, 1, 31'h7FFF_FFFF, 0, 32767, 1, 58, 0, 1 << 30, 70, 0);
    run_phase(0, 0, 32768, 0, 4096, 0, 0, 58, 65536, 60, 0);
    run_phase(200, 255, 0, 31'h7FFF_FFFF, 0, 15, 9, 9, 65536, 70, 0);
    run_phase(20, 10, 100000, 1000, 4096, 10, 0, 0, 200000, 90, 1);
    run_phase(128, 128, 31'h7FFF_FFFF, 0, 32767, 10, 9, 9, 1 << 20, 80, 0);
    run_phase(64, 100, 50000, 300, 12345, 2, 58, 0, 200000, 90, 0);
    run_phase(128, 128, 32768, 655, 2048, 4, 0, 58, 65536, 90, 0);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.answers_q.size() != 0) sb.report("answers left pending at the end");
    $display("tb: %0d beats in, %0d results, %0d queries with contacts, 8 settings",
             items_sent, sb.results, sb.contacts);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/dcs_pkg.sv
hdl/dcs_ram.sv
hdl/dcs_div.sv
hdl/dcs_match.sv
hdl/deep_contact_shadow.sv
hdl/dcs_chk.sv
tb/sv/deep_contact_shadow_test.sv
